// ----- src/cidd_pkg.sv -----
// Shared constants, types and helpers of the next-idle dispatcher.
package cidd_pkg;

  // Ring and field sizes
  localparam int unsigned MaxServers = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned NumW       = 5;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CntW       = 32;
  localparam int unsigned ArrW       = 31;
  localparam int unsigned DurW       = 31;
  localparam int unsigned MaskW      = 16;

  // Stream payload widths (packed, padded to whole bytes)
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 56;

  // Configuration port
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic [NumW-1:0] NumServersRst = NumW'(MaxServers);

  // Register word indexes
  typedef enum logic {
    REG_NUM_SERVERS = 1'b0
  } reg_idx_e;

  // Item kinds
  typedef enum logic {
    OP_DISPATCH = 1'b0,
    OP_REPORT   = 1'b1
  } op_e;

  // Reduce a 4-bit start index modulo the ring size, one quotient bit a step
  function automatic logic [IdxW-1:0] ring_mod(input logic [IdxW-1:0] start,
                                               input logic [NumW-1:0] n);
    logic [NumW:0] rem;
    rem = '0;
    for (int b = IdxW - 1; b >= 0; b--) begin
      rem = {rem[NumW-1:0], start[b]};
      if (rem >= {1'b0, n}) begin
        rem = rem - {1'b0, n};
      end
    end
    return rem[IdxW-1:0];
  endfunction

endpackage

// ----- src/circular_next_idle_dispatcher.sv -----
// Top level: round-robin next-idle server dispatcher with busiest-server report.
// Flow: input register, then result register, which loads when free or being read.
// Throughput: one item per cycle unless the result side stalls; the idle compare and
//   rotating pick over the in-use servers and the state update lie between the two.
// Reset: asynchronous, active low; clears server times, counts, start index,
//   maximum count and sets the ring size to sixteen.
module circular_next_idle_dispatcher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [30:0] arrival_time, [61:31] duration, [63:62] zero
  input  logic [cidd_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] op
  input  logic                            s_axis_tuser,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] server, [19:4] busiest_mask, [51:20] top_count, [55:52] zero
  output logic [cidd_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] dropped
  output logic                            m_axis_tuser,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cidd_pkg::AddrW-1:0]      paddr,
  input  logic [cidd_pkg::DataW-1:0]      pwdata,
  output logic [cidd_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned NSrv = cidd_pkg::MaxServers;

  // Configuration
  logic [cidd_pkg::NumW-1:0] num_servers_q;
  logic                      cfg_wr;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == cidd_pkg::REG_NUM_SERVERS);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? cidd_pkg::DataW'(num_servers_q) : '0;

  // Input register
  logic                       in_valid_q;
  logic                       in_op_q;
  logic [cidd_pkg::ArrW-1:0]  in_arr_q;
  logic [cidd_pkg::DurW-1:0]  in_dur_q;
  logic                       s_xfer;
  logic                       adv;

  // Result register
  logic                       out_valid_q;
  logic [cidd_pkg::IdxW-1:0]  out_server_q;
  logic                       out_dropped_q;
  logic [cidd_pkg::MaskW-1:0] out_mask_q;
  logic [cidd_pkg::CntW-1:0]  out_top_q;

  // Server state
  logic [cidd_pkg::TimeW-1:0] busy_q   [NSrv];
  logic [cidd_pkg::CntW-1:0]  served_q [NSrv];
  logic [cidd_pkg::IdxW-1:0]  start_q;
  logic [cidd_pkg::CntW-1:0]  max_q;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // Dispatch and report datapath
  logic [cidd_pkg::NumW-1:0]  ring_n;
  logic [cidd_pkg::IdxW-1:0]  start_eff;
  logic [cidd_pkg::IdxW-1:0]  start_nxt;
  logic [NSrv-1:0]            idle;
  logic [NSrv-1:0]            late;
  logic [NSrv-1:0]            top_hit;
  logic [cidd_pkg::IdxW-1:0]  pick;
  logic                       found;
  logic [cidd_pkg::TimeW-1:0] end_time;
  logic [cidd_pkg::CntW-1:0]  cnt_cur;
  logic [cidd_pkg::CntW-1:0]  cnt_new;
  logic [cidd_pkg::CntW-1:0]  max_new;
  logic                       is_disp;

  always_comb begin
    // Clamp the ring size
    if (num_servers_q == '0) begin
      ring_n = cidd_pkg::NumW'(1);
    end else if (num_servers_q > cidd_pkg::NumW'(NSrv)) begin
      ring_n = cidd_pkg::NumW'(NSrv);
    end else begin
      ring_n = num_servers_q;
    end

    start_eff = cidd_pkg::ring_mod(start_q, ring_n);
    start_nxt = ({1'b0, start_eff} + cidd_pkg::NumW'(1) == ring_n) ?
                '0 : start_eff + cidd_pkg::IdxW'(1);

    // Idle and busiest compares over the in-use servers
    for (int i = 0; i < NSrv; i++) begin
      idle[i]    = (cidd_pkg::NumW'(i) < ring_n) &&
                   (busy_q[i] <= {1'b0, in_arr_q});
      late[i]    = idle[i] && (cidd_pkg::NumW'(i) >= {1'b0, start_eff});
      top_hit[i] = (cidd_pkg::NumW'(i) < ring_n) && (served_q[i] == max_q);
    end

    // Rotating pick: first idle at or after start, else first idle overall
    found = |idle;
    pick  = '0;
    if (|late) begin
      for (int i = NSrv - 1; i >= 0; i--) begin
        if (late[i]) begin
          pick = cidd_pkg::IdxW'(i);
        end
      end
    end else begin
      for (int i = NSrv - 1; i >= 0; i--) begin
        if (idle[i]) begin
          pick = cidd_pkg::IdxW'(i);
        end
      end
    end

    // Both fields stay below 2^31, so the sum fits without saturation
    end_time = {1'b0, in_arr_q} + {1'b0, in_dur_q};
    cnt_cur  = served_q[pick];
    cnt_new  = (cnt_cur == '1) ? cnt_cur : cnt_cur + cidd_pkg::CntW'(1);
    is_disp  = (in_op_q == cidd_pkg::OP_DISPATCH);
    max_new  = (is_disp && found && (cnt_new > max_q)) ? cnt_new : max_q;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_servers_q <= cidd_pkg::NumServersRst;
    end else if (cfg_wr) begin
      num_servers_q <= pwdata[cidd_pkg::NumW-1:0];
    end
  end

  // Control state and server state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      start_q     <= '0;
      max_q       <= '0;
      for (int i = 0; i < NSrv; i++) begin
        busy_q[i]   <= '0;
        served_q[i] <= '0;
      end
    end else begin
      if (s_xfer) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // Commit a dispatch as it moves into the result register
      if (adv && is_disp) begin
        start_q <= start_nxt;
        max_q   <= max_new;
        if (found) begin
          busy_q[pick]   <= end_time;
          served_q[pick] <= cnt_new;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_op_q  <= s_axis_tuser;
      in_arr_q <= s_axis_tdata[cidd_pkg::ArrW-1:0];
      in_dur_q <= s_axis_tdata[cidd_pkg::ArrW +: cidd_pkg::DurW];
    end
    if (adv) begin
      out_server_q  <= (is_disp && found) ? pick : '0;
      out_dropped_q <= is_disp && !found;
      out_mask_q    <= is_disp ? '0 : cidd_pkg::MaskW'(top_hit);
      out_top_q     <= max_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_dropped_q;
  assign m_axis_tdata  = cidd_pkg::OutDataW'({out_top_q, out_mask_q, out_server_q});

  // Checks
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[19:0] == '0)
    else $error("dropped result carries a server or a mask");

  a_max_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> max_q >= $past(max_q))
    else $error("maximum count fell");

  a_busy_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_disp && found |=> busy_q[$past(pick)] == $past(end_time))
    else $error("chosen server busy time not updated");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_disp && found |=> served_q[$past(pick)] <= max_q)
    else $error("served count above maximum");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("advanced item produced no result");

endmodule

// ----- tb/dispatch_monitor.sv -----
// Checker for the next-idle dispatcher: tracks its state, predicts each result and compares.
`timescale 1ns / 1ps
module dispatch_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream as seen at the block's input
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  // [30:0] arrival_time, [61:31] duration, [63:62] zero
  input  logic [cidd_pkg::InDataW-1:0]  s_data_i,
  // [0] op
  input  logic                          s_user_i,
  // Result stream as seen at the block's output
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  // [3:0] server, [19:4] busiest_mask, [51:20] top_count, [55:52] zero
  input  logic [cidd_pkg::OutDataW-1:0] m_data_i,
  // [0] dropped
  input  logic                          m_user_i,
  // Configuration port
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [cidd_pkg::AddrW-1:0]    paddr_i,
  input  logic [cidd_pkg::DataW-1:0]    pwdata_i,
  // Counts for the top
  output int unsigned                   errors_o,
  output int unsigned                   pending_o,
  output int unsigned                   served_o,
  output int unsigned                   drops_o,
  output int unsigned                   reports_o,
  output int unsigned                   empty_masks_o
);

  localparam logic [cidd_pkg::AddrW-1:0] NumServersAddr =
    cidd_pkg::AddrW'(4 * int'(cidd_pkg::REG_NUM_SERVERS));

  typedef struct packed {
    logic [cidd_pkg::IdxW-1:0]  server;
    logic                       dropped;
    logic [cidd_pkg::MaskW-1:0] mask;
    logic [cidd_pkg::CntW-1:0]  top;
  } outcome_t;

  // Shadow copy of the dispatcher state
  logic [cidd_pkg::TimeW-1:0] busy_until [cidd_pkg::MaxServers];
  logic [cidd_pkg::CntW-1:0]  served     [cidd_pkg::MaxServers];
  logic [cidd_pkg::IdxW-1:0]  start_idx;
  logic [cidd_pkg::CntW-1:0]  max_served;
  logic [cidd_pkg::NumW-1:0]  ring_cfg;
  outcome_t                   outcome_q [$];

  task automatic report_mismatch(input string what, input logic [cidd_pkg::CntW-1:0] got,
                                 input logic [cidd_pkg::CntW-1:0] want);
    $display("%0t ns checker: %s got %0h expected %0h", $time, what, got, want);
    errors_o++;
  endtask

  // Apply one item to the shadow state and return the result it should give
  function automatic outcome_t predict_outcome(input cidd_pkg::op_e op,
                                               input logic [cidd_pkg::ArrW-1:0] arrival,
                                               input logic [cidd_pkg::DurW-1:0] dur);
    outcome_t                   res;
    int unsigned                n;
    int unsigned                first;
    int unsigned                s;
    int unsigned                pick;
    bit                         found;
    logic [cidd_pkg::TimeW:0]   finish;
    res   = '0;
    pick  = 0;
    found = 1'b0;
    n = (ring_cfg == 0) ? 1 :
        (ring_cfg > cidd_pkg::MaxServers) ? cidd_pkg::MaxServers : int'(ring_cfg);
    if (op == cidd_pkg::OP_REPORT) begin
      for (int i = 0; i < n; i++) begin
        if (served[i] == max_served) res.mask[i] = 1'b1;
      end
      if (res.mask == '0) empty_masks_o++;
      reports_o++;
    end else begin
      // Rotating search for the first idle server, start folded into the ring
      first = start_idx % n;
      for (int k = 0; k < n && !found; k++) begin
        s = (first + k) % n;
        if (busy_until[s] <= {1'b0, arrival}) begin
          found = 1'b1;
          pick  = s;
        end
      end
      if (found) begin
        finish = {2'b00, arrival} + {2'b00, dur};
        busy_until[pick] = finish[cidd_pkg::TimeW] ? '1 : finish[cidd_pkg::TimeW-1:0];
        if (served[pick] != '1) served[pick] = served[pick] + 1'b1;
        if (served[pick] > max_served) max_served = served[pick];
        res.server = cidd_pkg::IdxW'(pick);
        served_o++;
      end else begin
        res.dropped = 1'b1;
        drops_o++;
      end
      start_idx = cidd_pkg::IdxW'((first + 1) % n);
    end
    res.top = max_served;
    return res;
  endfunction

  // Compare results first, then take configuration and new requests
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t pred;
    if (!rst_ni) begin
      for (int i = 0; i < cidd_pkg::MaxServers; i++) begin
        busy_until[i] = '0;
        served[i]     = '0;
      end
      start_idx  = '0;
      max_served = '0;
      ring_cfg   = cidd_pkg::NumServersRst;
      outcome_q.delete();
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing pending", cidd_pkg::CntW'(m_data_i), '0);
        end else begin
          want = outcome_q.pop_front();
          if (m_data_i[0 +: cidd_pkg::IdxW] != want.server)
            report_mismatch("server", cidd_pkg::CntW'(m_data_i[0 +: cidd_pkg::IdxW]),
                            cidd_pkg::CntW'(want.server));
          if (m_user_i != want.dropped)
            report_mismatch("dropped", cidd_pkg::CntW'(m_user_i),
                            cidd_pkg::CntW'(want.dropped));
          if (m_data_i[cidd_pkg::IdxW +: cidd_pkg::MaskW] != want.mask)
            report_mismatch("busiest_mask",
                            cidd_pkg::CntW'(m_data_i[cidd_pkg::IdxW +: cidd_pkg::MaskW]),
                            cidd_pkg::CntW'(want.mask));
          if (m_data_i[cidd_pkg::IdxW+cidd_pkg::MaskW +: cidd_pkg::CntW] != want.top)
            report_mismatch("top_count",
                            m_data_i[cidd_pkg::IdxW+cidd_pkg::MaskW +: cidd_pkg::CntW],
                            want.top);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == NumServersAddr) begin
        ring_cfg = pwdata_i[cidd_pkg::NumW-1:0];
      end
      if (s_valid_i && s_ready_i) begin
        pred = predict_outcome(cidd_pkg::op_e'(s_user_i), s_data_i[0 +: cidd_pkg::ArrW],
                               s_data_i[cidd_pkg::ArrW +: cidd_pkg::DurW]);
        outcome_q = {outcome_q, pred};
      end
    end
    pending_o = outcome_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the next-idle dispatcher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned     HoldCycles   = 300;
  localparam int unsigned     QuietLimit   = 2000;
  localparam int unsigned     PhaseItems   = 175;
  localparam int unsigned     NumPhases    = 10;
  localparam logic [31:0]     PhaseSpacing = 32'd195225786;
  localparam logic [31:0]     ArrMax       = 32'h7FFF_FFFF;
  localparam logic [cidd_pkg::AddrW-1:0] NumServersAddr =
    cidd_pkg::AddrW'(4 * int'(cidd_pkg::REG_NUM_SERVERS));

  logic                          clk;
  logic                          rst_n;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [cidd_pkg::InDataW-1:0]  s_tdata;
  logic                          s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [cidd_pkg::OutDataW-1:0] m_tdata;
  logic                          m_tuser;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [cidd_pkg::AddrW-1:0]    paddr;
  logic [cidd_pkg::DataW-1:0]    pwdata;
  logic [cidd_pkg::DataW-1:0]    prdata;
  logic                          pready;

  int unsigned errors;
  int unsigned pending;
  int unsigned served_cnt;
  int unsigned drop_cnt;
  int unsigned report_cnt;
  int unsigned empty_cnt;
  int unsigned items_sent;
  int unsigned ring_writes;
  int unsigned quiet;
  bit          calm;
  bit          hold_req;

  circular_next_idle_dispatcher i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  dispatch_monitor i_monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_valid_i     (s_tvalid),
    .s_ready_i     (s_tready),
    .s_data_i      (s_tdata),
    .s_user_i      (s_tuser),
    .m_valid_i     (m_tvalid),
    .m_ready_i     (m_tready),
    .m_data_i      (m_tdata),
    .m_user_i      (m_tuser),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .errors_o      (errors),
    .pending_o     (pending),
    .served_o      (served_cnt),
    .drops_o       (drop_cnt),
    .reports_o     (report_cnt),
    .empty_masks_o (empty_cnt)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one request or report; random idle cycles unless in a calm stretch
  task automatic send_item(input cidd_pkg::op_e op, input logic [cidd_pkg::ArrW-1:0] arrival,
                           input logic [cidd_pkg::DurW-1:0] dur);
    while (!calm && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cidd_pkg::InDataW'({dur, arrival});
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  // Set-up and access cycle of a register write
  task automatic write_ring(input logic [cidd_pkg::NumW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NumServersAddr;
    pwdata  <= cidd_pkg::DataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ring_writes++;
  endtask

  // One ring setting with a rising time line and random request content
  task automatic run_phase(input logic [cidd_pkg::NumW-1:0] ring_raw,
                           input int unsigned phase_no, input int unsigned hold_at);
    logic [31:0]                now;
    logic [31:0]                arr;
    logic [cidd_pkg::DurW-1:0]  dur;
    int unsigned                n_eff;
    int unsigned                r;
    int unsigned                d;
    bit                         is_last;
    n_eff   = (ring_raw == 0) ? 1 :
              (ring_raw > cidd_pkg::MaxServers) ? cidd_pkg::MaxServers : int'(ring_raw);
    is_last = (phase_no == NumPhases - 1);
    now     = (phase_no + 1) * PhaseSpacing + $urandom_range(0, 1 << 20);
    drain_results();
    write_ring(ring_raw);
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      if (hold_at != 0 && i == hold_at) hold_req = 1'b1;
      r = $urandom_range(99);
      if (r < 10) begin
        send_item(cidd_pkg::OP_REPORT, cidd_pkg::ArrW'($urandom),
                  cidd_pkg::DurW'($urandom));
      end else if (r < 13) begin
        // stale arrival, at or before the time line
        d   = $urandom_range(0, 40);
        arr = (now > d) ? now - d : '0;
        send_item(cidd_pkg::OP_DISPATCH, arr[cidd_pkg::ArrW-1:0],
                  cidd_pkg::DurW'($urandom_range(0, 8 * n_eff)));
      end else begin
        now = (now + $urandom_range(0, 6) > ArrMax) ? ArrMax : now + $urandom_range(0, 6);
        d   = $urandom_range(99);
        if (is_last && d < 3) dur = cidd_pkg::DurW'($urandom);
        else if (n_eff >= 4 && d < 2) dur = cidd_pkg::DurW'($urandom_range(0, 1 << 24));
        else dur = cidd_pkg::DurW'($urandom_range(0, 8 * n_eff));
        send_item(cidd_pkg::OP_DISPATCH, now[cidd_pkg::ArrW-1:0], dur);
      end
    end
  endtask

  // Result side: random back-pressure plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  // End the run after too long without any transfer
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Stimulus and verdict
  initial begin
    logic [cidd_pkg::NumW-1:0] ring_plan [NumPhases];
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    ring_plan = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd5, 5'd31, 5'd8, 5'd12,
                  cidd_pkg::NumW'($urandom_range(1, 16)),
                  cidd_pkg::NumW'($urandom_range(0, 31))};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: report before any dispatch, fill the ring, extreme times onto the last server
    send_item(cidd_pkg::OP_REPORT, '0, '0);
    repeat (15) send_item(cidd_pkg::OP_DISPATCH, '0, '0);
    send_item(cidd_pkg::OP_DISPATCH, '1, '1);
    send_item(cidd_pkg::OP_REPORT, '1, '1);
    send_item(cidd_pkg::OP_DISPATCH, cidd_pkg::ArrW'(0), cidd_pkg::DurW'(7));
    send_item(cidd_pkg::OP_DISPATCH, cidd_pkg::ArrW'(2), cidd_pkg::DurW'(0));
    // Zero ring size acts as one server; start folds into the ring; busy drop
    drain_results();
    write_ring(5'd0);
    send_item(cidd_pkg::OP_DISPATCH, cidd_pkg::ArrW'(3), cidd_pkg::DurW'(0));
    send_item(cidd_pkg::OP_DISPATCH, cidd_pkg::ArrW'(7), cidd_pkg::DurW'(4));
    send_item(cidd_pkg::OP_REPORT, '0, '0);
    // Oversized ring acts as the full sixteen
    drain_results();
    write_ring(5'd31);
    send_item(cidd_pkg::OP_REPORT, '0, '0);

    // Random phases over several ring sizes, one calm, one with a long stall
    for (int unsigned p = 0; p < NumPhases; p++) begin
      calm = (p == 4);
      run_phase(ring_plan[p], p, (p == 2) ? 60 : 0);
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("summary: %0d items under %0d ring settings: %0d served, %0d dropped,",
             items_sent, ring_writes, served_cnt, drop_cnt);
    $display("summary: %0d busiest-server reports, %0d of them with an empty mask",
             report_cnt, empty_cnt);
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- circular_next_idle_dispatcher.f -----
src/cidd_pkg.sv
src/circular_next_idle_dispatcher.sv
tb/dispatch_monitor.sv
tb/tb.sv
